### design/pcip_pkg.sv
// Shared widths, reset values, register indexes and types for the clamp/integrate/peak core.
`timescale 1ns / 1ps
`default_nettype none

package pcip_pkg;

  localparam int SampleW    = 16;
  localparam int MaxSamples = 65536;
  localparam int CountW     = $clog2(MaxSamples);
  localparam int SumW       = 32;
  localparam int PeriodW    = 24;
  localparam int IntegW     = 56;
  localparam int CfgIdxW    = 2;
  localparam int CfgDataW   = 24;

  localparam logic signed [SampleW-1:0] ClampHighRst = 16'sh7fff;
  localparam logic signed [SampleW-1:0] ClampLowRst  = 16'sh8000;
  localparam logic [PeriodW-1:0]        PeriodRst    = 24'd4398;

  localparam logic signed [SumW-1:0] SumMax = {1'b0, {(SumW-1){1'b1}}};
  localparam logic signed [SumW-1:0] SumMin = {1'b1, {(SumW-1){1'b0}}};
  localparam logic [CountW-1:0]      CountMax = CountW'(MaxSamples - 1);

  typedef enum logic [CfgIdxW-1:0] {
    CfgClampHigh    = 2'd0,
    CfgClampLow     = 2'd1,
    CfgSamplePeriod = 2'd2
  } cfg_idx_e;

  // per-word summary handed from the accumulator to the output stage
  typedef struct packed {
    logic                      done;
    logic                      was_clamped;
    logic signed [SumW-1:0]    sum;
    logic signed [SampleW-1:0] amplitude;
    logic [CountW-1:0]         peak_index;
  } summ_t;

endpackage

`default_nettype wire

### design/pcip_accum.sv
// Waveform accumulator: saturating sum, first minimum with index, clamp flag.
`timescale 1ns / 1ps
`default_nettype none

module pcip_accum import pcip_pkg::*; (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      en_i,
  input  wire logic signed [SampleW-1:0] c_i,
  input  wire logic                      hit_i,
  input  wire logic                      last_i,
  output logic signed [SampleW-1:0]      c_o,
  output summ_t                          summ_o
);

  logic signed [SumW-1:0]    sum_q, sum_d;
  logic signed [SampleW-1:0] min_q, min_d;
  logic                      min_valid_q;
  logic [CountW-1:0]         idx_q, idx_d;
  logic [CountW-1:0]         count_q, count_d;
  logic                      seen_q, seen_d;
  logic signed [SumW:0]      sum_ext;
  logic                      take_min;
  logic signed [SampleW-1:0] c_q;
  summ_t                     summ_q, summ_d;

  always_comb begin
    sum_ext = {sum_q[SumW-1], sum_q} + (SumW+1)'(c_i);
    if (sum_ext[SumW] != sum_ext[SumW-1]) begin
      sum_d = sum_ext[SumW] ? SumMin : SumMax;
    end else begin
      sum_d = sum_ext[SumW-1:0];
    end
    // first word of a waveform always wins; later ones only when strictly smaller
    take_min = !min_valid_q || (c_i < min_q);
    min_d    = take_min ? c_i : min_q;
    idx_d    = take_min ? count_q : idx_q;
    seen_d   = seen_q | hit_i;
    count_d  = (count_q != CountMax) ? count_q + 1'b1 : count_q;

    summ_d = '0;
    if (last_i) begin
      summ_d.done        = 1'b1;
      summ_d.was_clamped = seen_d;
      summ_d.sum         = sum_d;
      summ_d.amplitude   = min_d;
      summ_d.peak_index  = idx_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q       <= '0;
      min_q       <= '0;
      min_valid_q <= 1'b0;
      idx_q       <= '0;
      count_q     <= '0;
      seen_q      <= 1'b0;
    end else if (en_i) begin
      if (last_i) begin
        sum_q       <= '0;
        min_q       <= '0;
        min_valid_q <= 1'b0;
        idx_q       <= '0;
        count_q     <= '0;
        seen_q      <= 1'b0;
      end else begin
        sum_q       <= sum_d;
        min_q       <= min_d;
        min_valid_q <= 1'b1;
        idx_q       <= idx_d;
        count_q     <= count_d;
        seen_q      <= seen_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      c_q    <= c_i;
      summ_q <= summ_d;
    end
  end

  assign c_o    = c_q;
  assign summ_o = summ_q;

endmodule

`default_nettype wire

### design/pulse_clamp_integrate_peak_core.sv
// Top level of the waveform clamp, integral and peak finder.
`timescale 1ns / 1ps
`default_nettype none

// Clamps each signed sample word into [clamp_low, clamp_high] and returns it,
// one result word per input word. The core keeps a saturating 32-bit sum of
// the clamped samples, the smallest clamped sample with the index of its
// first occurrence, and a clamped-anywhere flag. On a word marked last it
// also reports integral = sum * sample_period (2^-40 s units, 56 bits signed),
// the minimum amplitude, the peak index and the flag, then clears the
// waveform state. Throughput is one word per clock while the output is not
// stalled; it holds three registers (clamp, accumulator, multiply/output).
// The rate is set by the add-saturate-compare loop in the accumulator.
// With limits crossed (low above high) a sample failing both tests leaves as
// clamp_low. Configuration is to be written only while the core is empty.

module pulse_clamp_integrate_peak_core import pcip_pkg::*; (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  // configuration write port
  input  wire logic                      cfg_we_i,
  input  wire logic [CfgIdxW-1:0]        cfg_idx_i,
  input  wire logic [CfgDataW-1:0]       cfg_data_i,
  // input channel
  input  wire logic                      in_valid_i,
  output logic                           in_stall_o,
  input  wire logic signed [SampleW-1:0] sample_i,
  input  wire logic                      last_i,
  // output channel
  output logic                           out_valid_o,
  input  wire logic                      out_stall_i,
  output logic signed [SampleW-1:0]      clamped_sample_o,
  output logic                           done_res_o,
  output logic                           was_clamped_o,
  output logic signed [IntegW-1:0]       integral_o,
  output logic signed [SampleW-1:0]      amplitude_o,
  output logic [CountW-1:0]              peak_index_o
);

  // configuration registers
  logic signed [SampleW-1:0] clamp_high_q;
  logic signed [SampleW-1:0] clamp_low_q;
  logic [PeriodW-1:0]        period_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clamp_high_q <= ClampHighRst;
      clamp_low_q  <= ClampLowRst;
      period_q     <= PeriodRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgClampHigh:    clamp_high_q <= cfg_data_i[SampleW-1:0];
        CfgClampLow:     clamp_low_q  <= cfg_data_i[SampleW-1:0];
        CfgSamplePeriod: period_q     <= cfg_data_i[PeriodW-1:0];
        default: ;
      endcase
    end
  end

  // pipeline flow: a stage moves when it is empty or the next one moves
  logic v1_q, v2_q, v3_q;
  logic adv1, adv2, adv3;
  logic in_acc;

  assign adv3       = !v3_q || !out_stall_i;
  assign adv2       = !v2_q || adv3;
  assign adv1       = !v1_q || adv2;
  assign in_stall_o = !adv1;
  assign in_acc     = in_valid_i && adv1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (adv1) v1_q <= in_valid_i;
      if (adv2) v2_q <= v1_q;
      if (adv3) v3_q <= v2_q;
    end
  end

  // stage 1: clamp; upper test first, lower test overrides
  logic signed [SampleW-1:0] c_d, c1_q;
  logic                      hit_d, hit1_q, last1_q;

  always_comb begin
    c_d   = sample_i;
    hit_d = 1'b0;
    if (sample_i > clamp_high_q) begin
      c_d   = clamp_high_q;
      hit_d = 1'b1;
    end
    if (sample_i < clamp_low_q) begin
      c_d   = clamp_low_q;
      hit_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      c1_q    <= c_d;
      hit1_q  <= hit_d;
      last1_q <= last_i;
    end
  end

  // stage 2: waveform accumulator
  logic signed [SampleW-1:0] c2;
  summ_t                     summ2;

  pcip_accum u_accum (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (v1_q && adv2),
    .c_i    (c1_q),
    .hit_i  (hit1_q),
    .last_i (last1_q),
    .c_o    (c2),
    .summ_o (summ2)
  );

  // stage 3: integral multiply into the output register
  // full product of 32-bit sum and 24-bit period fits in 56 signed bits
  logic signed [IntegW-1:0]  prod;
  logic signed [SampleW-1:0] c3_q;
  logic                      done3_q, clamped3_q;
  logic signed [IntegW-1:0]  integ3_q;
  logic signed [SampleW-1:0] amp3_q;
  logic [CountW-1:0]         idx3_q;

  assign prod = summ2.sum * $signed({1'b0, period_q});

  always_ff @(posedge clk_i) begin
    if (v2_q && adv3) begin
      c3_q       <= c2;
      done3_q    <= summ2.done;
      clamped3_q <= summ2.was_clamped;
      integ3_q   <= prod;
      amp3_q     <= summ2.amplitude;
      idx3_q     <= summ2.peak_index;
    end
  end

  assign out_valid_o      = v3_q;
  assign clamped_sample_o = c3_q;
  assign done_res_o       = done3_q;
  assign was_clamped_o    = clamped3_q;
  assign integral_o       = integ3_q;
  assign amplitude_o      = amp3_q;
  assign peak_index_o     = idx3_q;

endmodule

`default_nettype wire
